// ===== sv/pairwise_repulsive_force_assert.svh =====
// Assertion macros for the pairwise repulsive force block.
// Used by the top level only; depends on nothing else.
`ifndef PAIRWISE_REPULSIVE_FORCE_ASSERT_SVH
`define PAIRWISE_REPULSIVE_FORCE_ASSERT_SVH

// Same-cycle implication, off during reset
`define PRF_ASSERT_NOW(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("prf check failed");

// Next-cycle implication, off during reset
`define PRF_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("prf check failed");

`endif

// ===== sv/prf_pkg.sv =====
// Shared types and constants of the pairwise repulsive force block.
// Used by every module of the block; depends on nothing.
package prf_pkg;

   localparam int unsigned POS_W       = 32;
   localparam int unsigned ACC_W       = 64;
   localparam int unsigned WIDE_W      = 96;
   localparam int unsigned CSR_IDX_W   = 2;
   localparam int unsigned SQRT_STAGES = 32;
   localparam int unsigned DIV_STAGES  = 64;

   localparam logic [POS_W-1:0] CUTOFF_LEN_RST = 32'd167772;
   localparam logic [POS_W-1:0] MIN_DIST_RST   = 32'd1678;
   localparam logic [POS_W-1:0] INV_MASS_RST   = 32'd6553600;

   localparam logic [ACC_W-1:0] SAT_POS = {1'b0, {(ACC_W-1){1'b1}}};
   localparam logic [ACC_W-1:0] SAT_NEG = {1'b1, {(ACC_W-1){1'b0}}};

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CUTOFF_LEN = 2'd0,
      CSR_MIN_DIST   = 2'd1,
      CSR_INV_MASS   = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [POS_W-1:0] own_x;
      logic [POS_W-1:0] own_y;
      logic [POS_W-1:0] other_x;
      logic [POS_W-1:0] other_y;
   } req_type;

   typedef struct packed {
      logic signed [ACC_W-1:0] accel_x;
      logic signed [ACC_W-1:0] accel_y;
      logic                    interacts;
   } rsp_type;

   // Travels alongside the square root stages
   typedef struct packed {
      logic             live;
      logic             zero;
      logic             xneg;
      logic             yneg;
      logic [POS_W-1:0] xmag;
      logic [POS_W-1:0] ymag;
      logic [ACC_W-1:0] r2;
   } sqrt_side_type;

   // Travels alongside the divider stages
   typedef struct packed {
      logic neg;
      logic live;
      logic zero;
   } div_side_type;

endpackage

// ===== sv/prf_isqrt.sv =====
// Pipelined integer square root, one result bit per stage.
// Depends on prf_pkg for the sideband type and stage count.
module prf_isqrt (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  logic                   in_vld,
   input  prf_pkg::sqrt_side_type in_side,
   output logic                   out_vld,
   output logic [31:0]            out_root,
   output prf_pkg::sqrt_side_type out_side
);

   localparam int unsigned N = prf_pkg::SQRT_STAGES;

   logic [N-1:0]           vld_ff;
   logic [31:0]            root_ff [N];
   logic [33:0]            rem_ff  [N];
   prf_pkg::sqrt_side_type side_ff [N];

   for (genvar k = 0; k < N; k++) begin : g_stage
      localparam int unsigned J = N - 1 - k;
      logic                   vld_p;
      logic [31:0]            root_p;
      logic [33:0]            rem_p;
      prf_pkg::sqrt_side_type side_p;
      logic [35:0]            rem_sh;
      logic [35:0]            trial;
      logic [33:0]            rem_in;
      logic [31:0]            root_in;

      if (k == 0) begin : g_first
         assign vld_p  = in_vld;
         assign root_p = '0;
         assign rem_p  = '0;
         assign side_p = in_side;
      end else begin : g_next
         assign vld_p  = vld_ff[k-1];
         assign root_p = root_ff[k-1];
         assign rem_p  = rem_ff[k-1];
         assign side_p = side_ff[k-1];
      end

      // bring down the next two radicand bits and try the next root bit
      always_comb begin
         rem_sh = {rem_p, side_p.r2[2*J+1 -: 2]};
         trial  = {2'b00, root_p, 2'b01};
         if (rem_sh >= trial) begin
            rem_in  = 34'(rem_sh - trial);
            root_in = {root_p[30:0], 1'b1};
         end else begin
            rem_in  = rem_sh[33:0];
            root_in = {root_p[30:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en) begin
            vld_ff[k] <= vld_p;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            root_ff[k] <= root_in;
            rem_ff[k]  <= rem_in;
            side_ff[k] <= side_p;
         end
      end
   end

   assign out_vld  = vld_ff[N-1];
   assign out_root = root_ff[N-1];
   assign out_side = side_ff[N-1];

endmodule

// ===== sv/prf_div.sv =====
// Pipelined restoring divider for one axis, with saturation and sign.
// Depends on prf_pkg for widths, saturation limits and the sideband type.
module prf_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       en,
   input  logic                       in_vld,
   input  logic [prf_pkg::WIDE_W-1:0] num,
   input  logic [prf_pkg::WIDE_W-1:0] den,
   input  prf_pkg::div_side_type      in_side,
   output logic                       out_vld,
   output logic signed [63:0]         out_accel,
   output logic                       out_live
);

   localparam int unsigned N = prf_pkg::DIV_STAGES;
   localparam int unsigned W = prf_pkg::WIDE_W;

   // first stage: overflow check and initial remainder
   logic                  s0_vld_ff;
   logic [W-1:0]          s0_rem_ff;
   logic [31:0]           s0_plow_ff;
   logic [W-1:0]          s0_den_ff;
   logic                  s0_big_ff;
   prf_pkg::div_side_type s0_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_vld_ff <= 1'b0;
      end else if (en) begin
         s0_vld_ff <= in_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s0_rem_ff  <= {32'd0, num[W-1:32]};
         s0_plow_ff <= num[31:0];
         s0_den_ff  <= den;
         s0_big_ff  <= ({32'd0, num[W-1:32]} >= den);
         s0_side_ff <= in_side;
      end
   end

   logic [N-1:0]          vld_ff;
   logic [W-1:0]          rem_ff  [N];
   logic [31:0]           plow_ff [N];
   logic [W-1:0]          den_ff  [N];
   logic [63:0]           q_ff    [N];
   logic                  big_ff  [N];
   prf_pkg::div_side_type side_ff [N];

   for (genvar k = 0; k < N; k++) begin : g_stage
      logic                  vld_p;
      logic [W-1:0]          rem_p;
      logic [31:0]           plow_p;
      logic [W-1:0]          den_p;
      logic [63:0]           q_p;
      logic                  big_p;
      prf_pkg::div_side_type side_p;
      logic [W:0]            rem_sh;
      logic                  ge;

      if (k == 0) begin : g_first
         assign vld_p  = s0_vld_ff;
         assign rem_p  = s0_rem_ff;
         assign plow_p = s0_plow_ff;
         assign den_p  = s0_den_ff;
         assign q_p    = '0;
         assign big_p  = s0_big_ff;
         assign side_p = s0_side_ff;
      end else begin : g_next
         assign vld_p  = vld_ff[k-1];
         assign rem_p  = rem_ff[k-1];
         assign plow_p = plow_ff[k-1];
         assign den_p  = den_ff[k-1];
         assign q_p    = q_ff[k-1];
         assign big_p  = big_ff[k-1];
         assign side_p = side_ff[k-1];
      end

      // shift in the next dividend bit and compare against the divisor
      assign rem_sh = {rem_p, plow_p[31]};
      assign ge     = (rem_sh >= {1'b0, den_p});

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en) begin
            vld_ff[k] <= vld_p;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= ge ? W'(rem_sh - {1'b0, den_p}) : rem_sh[W-1:0];
            plow_ff[k] <= {plow_p[30:0], 1'b0};
            den_ff[k]  <= den_p;
            q_ff[k]    <= {q_p[62:0], ge};
            big_ff[k]  <= big_p;
            side_ff[k] <= side_p;
         end
      end
   end

   // saturate the magnitude, apply the sign, drop to zero when out of range or at zero distance
   logic [63:0]           q_last;
   prf_pkg::div_side_type side_last;
   logic                  over;
   logic [63:0]           mag;
   logic [63:0]           accel_in;

   assign q_last    = q_ff[N-1];
   assign side_last = side_ff[N-1];

   always_comb begin
      if (side_last.neg) begin
         over = big_ff[N-1] || (q_last[63] && (q_last[62:0] != '0));
         mag  = over ? prf_pkg::SAT_NEG : q_last;
      end else begin
         over = big_ff[N-1] || q_last[63];
         mag  = over ? prf_pkg::SAT_POS : q_last;
      end
      if (!side_last.live || side_last.zero) begin
         accel_in = '0;
      end else if (side_last.neg) begin
         accel_in = 64'(64'd0 - mag);
      end else begin
         accel_in = mag;
      end
   end

   logic              out_vld_ff;
   logic signed [63:0] out_accel_ff;
   logic              out_live_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (en) begin
         out_vld_ff <= vld_ff[N-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_accel_ff <= accel_in;
         out_live_ff  <= side_last.live;
      end
   end

   assign out_vld   = out_vld_ff;
   assign out_accel = out_accel_ff;
   assign out_live  = out_live_ff;

endmodule

// ===== sv/pairwise_repulsive_force.sv =====
// Usage of the pairwise repulsive force block.
// req channel: one particle/neighbor position pair per item (req_item), taken
//   at a clock edge with req_valid high and req_stall low.
// rsp channel: one result per item (rsp_item: accel_x, accel_y, interacts),
//   handed over at an edge with rsp_valid high and rsp_stall low.
// csr channel: register writes by index (cutoff_len, min_dist, inv_mass);
//   csr_ready is always high. Write only while no item is in flight.
// Throughput: one item per cycle, sustained while the pipeline is not stalled.
// Path from acceptance to rsp_valid: the 32-stage
//   square root, the 64-stage per-axis dividers plus their entry and output
//   registers, and 7 other stages for differences, squares and products.
// Stall: while rsp_valid is high and rsp_stall is high the whole pipeline
//   holds and req_stall is raised; nothing is lost or repeated.
// Reset (synchronous, active high): clears every stage valid bit and loads
//   the registers with their default values.
// Dependencies: prf_pkg, prf_isqrt, prf_div, pairwise_repulsive_force_assert.svh.
`include "pairwise_repulsive_force_assert.svh"

module pairwise_repulsive_force (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  prf_pkg::req_type              req_item,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output prf_pkg::rsp_type              rsp_item,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [prf_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]                   csr_wdata
);

   // configuration registers
   logic [31:0] cutoff_ff;
   logic [31:0] min_ff;
   logic [31:0] mass_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cutoff_ff <= prf_pkg::CUTOFF_LEN_RST;
         min_ff    <= prf_pkg::MIN_DIST_RST;
         mass_ff   <= prf_pkg::INV_MASS_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            prf_pkg::CSR_CUTOFF_LEN: cutoff_ff <= csr_wdata;
            prf_pkg::CSR_MIN_DIST:   min_ff    <= csr_wdata;
            prf_pkg::CSR_INV_MASS:   mass_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // global advance: hold everything while a result waits on a stall
   logic en;
   assign en        = !(rsp_valid && rsp_stall);
   assign req_stall = !en;

   // stage A: signed differences as sign and magnitude
   logic        a_vld_ff;
   logic        a_xneg_ff, a_yneg_ff;
   logic [31:0] a_xmag_ff, a_ymag_ff;
   logic        a_xneg_in, a_yneg_in;

   assign a_xneg_in = req_item.other_x < req_item.own_x;
   assign a_yneg_in = req_item.other_y < req_item.own_y;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else if (en) begin
         a_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_xneg_ff <= a_xneg_in;
         a_yneg_ff <= a_yneg_in;
         a_xmag_ff <= a_xneg_in ? req_item.own_x - req_item.other_x
                                : req_item.other_x - req_item.own_x;
         a_ymag_ff <= a_yneg_in ? req_item.own_y - req_item.other_y
                                : req_item.other_y - req_item.own_y;
      end
   end

   // stage B: squares of the differences and of the limits
   logic        b_vld_ff;
   logic        b_xneg_ff, b_yneg_ff;
   logic [31:0] b_xmag_ff, b_ymag_ff;
   logic [63:0] b_sx_ff, b_sy_ff, b_csq_ff, b_msq_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_vld_ff <= 1'b0;
      end else if (en) begin
         b_vld_ff <= a_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         b_xneg_ff <= a_xneg_ff;
         b_yneg_ff <= a_yneg_ff;
         b_xmag_ff <= a_xmag_ff;
         b_ymag_ff <= a_ymag_ff;
         b_sx_ff   <= 64'(a_xmag_ff) * 64'(a_xmag_ff);
         b_sy_ff   <= 64'(a_ymag_ff) * 64'(a_ymag_ff);
         b_csq_ff  <= 64'(cutoff_ff) * 64'(cutoff_ff);
         b_msq_ff  <= 64'(min_ff) * 64'(min_ff);
      end
   end

   // stage C: cutoff test and clamp of the squared distance
   logic                   c_vld_ff;
   prf_pkg::sqrt_side_type c_side_ff;
   logic [64:0]            c_sum;
   logic [63:0]            c_r2;
   prf_pkg::sqrt_side_type c_side_in;

   always_comb begin
      c_sum = {1'b0, b_sx_ff} + {1'b0, b_sy_ff};
      c_r2  = (c_sum[63:0] < b_msq_ff) ? b_msq_ff : c_sum[63:0];
      c_side_in.live = !(c_sum > {1'b0, b_csq_ff});
      c_side_in.zero = (c_r2 == '0);
      c_side_in.xneg = b_xneg_ff;
      c_side_in.yneg = b_yneg_ff;
      c_side_in.xmag = b_xmag_ff;
      c_side_in.ymag = b_ymag_ff;
      c_side_in.r2   = c_r2;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_vld_ff <= 1'b0;
      end else if (en) begin
         c_vld_ff <= b_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c_side_ff <= c_side_in;
      end
   end

   // distance by square root
   logic                   s_vld;
   logic [31:0]            s_root;
   prf_pkg::sqrt_side_type s_side;

   prf_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_vld   (c_vld_ff),
      .in_side  (c_side_ff),
      .out_vld  (s_vld),
      .out_root (s_root),
      .out_side (s_side)
   );

   // stage D: distance to the cutoff and partial products of r * r2
   logic        d_vld_ff;
   logic        d_gneg_ff;
   logic [31:0] d_dist_ff;
   logic [63:0] d_den_lo_ff, d_den_hi_ff;
   logic        d_live_ff, d_zero_ff, d_xneg_ff, d_yneg_ff;
   logic [31:0] d_xmag_ff, d_ymag_ff;
   logic        d_gneg_in;

   assign d_gneg_in = s_root < cutoff_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         d_vld_ff <= 1'b0;
      end else if (en) begin
         d_vld_ff <= s_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d_gneg_ff   <= d_gneg_in;
         d_dist_ff   <= d_gneg_in ? cutoff_ff - s_root : s_root - cutoff_ff;
         d_den_lo_ff <= 64'(s_root) * 64'(s_side.r2[31:0]);
         d_den_hi_ff <= 64'(s_root) * 64'(s_side.r2[63:32]);
         d_live_ff   <= s_side.live;
         d_zero_ff   <= s_side.zero;
         d_xneg_ff   <= s_side.xneg;
         d_yneg_ff   <= s_side.yneg;
         d_xmag_ff   <= s_side.xmag;
         d_ymag_ff   <= s_side.ymag;
      end
   end

   // stage E: scale by inverse mass, assemble the divisor
   logic        e_vld_ff;
   logic [63:0] e_g_ff;
   logic [95:0] e_den_ff;
   logic        e_nx_ff, e_ny_ff, e_live_ff, e_zero_ff;
   logic [31:0] e_xmag_ff, e_ymag_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         e_vld_ff <= 1'b0;
      end else if (en) begin
         e_vld_ff <= d_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         e_g_ff    <= 64'(d_dist_ff) * 64'(mass_ff);
         e_den_ff  <= {32'd0, d_den_lo_ff} + {d_den_hi_ff, 32'd0};
         e_nx_ff   <= d_xneg_ff ^ d_gneg_ff;
         e_ny_ff   <= d_yneg_ff ^ d_gneg_ff;
         e_live_ff <= d_live_ff;
         e_zero_ff <= d_zero_ff;
         e_xmag_ff <= d_xmag_ff;
         e_ymag_ff <= d_ymag_ff;
      end
   end

   // stage F: partial products of the numerators
   logic        f_vld_ff;
   logic [63:0] f_pxl_ff, f_pxh_ff, f_pyl_ff, f_pyh_ff;
   logic [95:0] f_den_ff;
   logic        f_nx_ff, f_ny_ff, f_live_ff, f_zero_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         f_vld_ff <= 1'b0;
      end else if (en) begin
         f_vld_ff <= e_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         f_pxl_ff  <= 64'(e_g_ff[31:0]) * 64'(e_xmag_ff);
         f_pxh_ff  <= 64'(e_g_ff[63:32]) * 64'(e_xmag_ff);
         f_pyl_ff  <= 64'(e_g_ff[31:0]) * 64'(e_ymag_ff);
         f_pyh_ff  <= 64'(e_g_ff[63:32]) * 64'(e_ymag_ff);
         f_den_ff  <= e_den_ff;
         f_nx_ff   <= e_nx_ff;
         f_ny_ff   <= e_ny_ff;
         f_live_ff <= e_live_ff;
         f_zero_ff <= e_zero_ff;
      end
   end

   // stage G: assemble the numerators
   logic                  g_vld_ff;
   logic [95:0]           g_px_ff, g_py_ff, g_den_ff;
   prf_pkg::div_side_type g_sx_ff, g_sy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         g_vld_ff <= 1'b0;
      end else if (en) begin
         g_vld_ff <= f_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         g_px_ff      <= {32'd0, f_pxl_ff} + {f_pxh_ff, 32'd0};
         g_py_ff      <= {32'd0, f_pyl_ff} + {f_pyh_ff, 32'd0};
         g_den_ff     <= f_den_ff;
         g_sx_ff.neg  <= f_nx_ff;
         g_sx_ff.live <= f_live_ff;
         g_sx_ff.zero <= f_zero_ff;
         g_sy_ff.neg  <= f_ny_ff;
         g_sy_ff.live <= f_live_ff;
         g_sy_ff.zero <= f_zero_ff;
      end
   end

   // per-axis division and saturation
   logic               x_vld, y_vld, x_live, y_live;
   logic signed [63:0] x_accel, y_accel;

   prf_div u_div_x (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_vld    (g_vld_ff),
      .num       (g_px_ff),
      .den       (g_den_ff),
      .in_side   (g_sx_ff),
      .out_vld   (x_vld),
      .out_accel (x_accel),
      .out_live  (x_live)
   );

   prf_div u_div_y (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_vld    (g_vld_ff),
      .num       (g_py_ff),
      .den       (g_den_ff),
      .in_side   (g_sy_ff),
      .out_vld   (y_vld),
      .out_accel (y_accel),
      .out_live  (y_live)
   );

   assign rsp_valid          = x_vld;
   assign rsp_item.accel_x   = x_accel;
   assign rsp_item.accel_y   = y_accel;
   assign rsp_item.interacts = x_live & y_live;

   // checks
   `PRF_ASSERT_NOW(a_axes_in_step, clock, reset, x_vld || y_vld, x_vld && y_vld)
   `PRF_ASSERT_NOW(a_far_is_zero, clock, reset, rsp_valid && !rsp_item.interacts,
                   rsp_item.accel_x == '0 && rsp_item.accel_y == '0)
   `PRF_ASSERT_NEXT(a_stall_holds, clock, reset, rsp_valid && rsp_stall,
                    $stable(a_vld_ff) && $stable(c_vld_ff) && $stable(g_vld_ff))

endmodule

// ===== sim/pairwise_repulsive_force_tb.sv =====
// Self-checking bench for the pairwise repulsive force block.
// Depends on prf_pkg and the pairwise_repulsive_force top level only.
`timescale 1ns / 1ps

module pairwise_repulsive_force_tb;

   localparam logic [prf_pkg::CSR_IDX_W-1:0] CSR_SPARE = 2'd3;
   localparam int DRAIN_CYCLES = 120;
   localparam int IDLE_LIMIT   = 3000;
   localparam int LONG_HOLD    = 400;

   // Expected accelerations for each accepted pair, oldest first
   class force_scoreboard;
      logic [31:0]      cutoff, min_d, inv_m;
      prf_pkg::rsp_type pending[$];
      int               fails;

      function new();
         cutoff = prf_pkg::CUTOFF_LEN_RST;
         min_d  = prf_pkg::MIN_DIST_RST;
         inv_m  = prf_pkg::INV_MASS_RST;
         fails  = 0;
      endfunction

      function void set_reg(logic [prf_pkg::CSR_IDX_W-1:0] idx, logic [31:0] v);
         case (idx)
            prf_pkg::CSR_CUTOFF_LEN: cutoff = v;
            prf_pkg::CSR_MIN_DIST:   min_d  = v;
            prf_pkg::CSR_INV_MASS:   inv_m  = v;
            default: ;
         endcase
      endfunction

      function logic [31:0] root(logic [63:0] n);
         logic [31:0] res;
         logic [31:0] t;
         res = '0;
         for (int i = 31; i >= 0; i--) begin
            t = res | (32'd1 << i);
            if (64'(t) * 64'(t) <= n) res = t;
         end
         return res;
      endfunction

      // Quotient rounded toward zero, then saturated by sign
      function logic [63:0] axis(logic [31:0] dm, bit dn, logic [63:0] g, bit gn,
                                 logic [95:0] den);
         logic [127:0] num, qt;
         logic [63:0]  cap, mag;
         bit           neg;
         neg = dn != gn;
         num = (128'(g) * 128'(dm)) << 32;
         qt  = num / 128'(den);
         cap = neg ? prf_pkg::SAT_NEG : prf_pkg::SAT_POS;
         mag = (qt > 128'(cap)) ? cap : qt[63:0];
         return neg ? -mag : mag;
      endfunction

      function prf_pkg::rsp_type predict(prf_pkg::req_type q);
         logic [31:0]      xm, ym, r, d;
         logic [64:0]      s;
         logic [63:0]      r2, fl, g;
         logic [95:0]      den;
         bit               xn, yn, gn;
         prf_pkg::rsp_type o;
         o  = '0;
         xn = q.other_x < q.own_x;
         yn = q.other_y < q.own_y;
         xm = xn ? q.own_x - q.other_x : q.other_x - q.own_x;
         ym = yn ? q.own_y - q.other_y : q.other_y - q.own_y;
         s  = 65'(xm) * 65'(xm) + 65'(ym) * 65'(ym);
         // out of range, including a sum beyond 64 bits
         if (s[64] || s[63:0] > 64'(cutoff) * 64'(cutoff)) return o;
         o.interacts = 1'b1;
         r2 = s[63:0];
         fl = 64'(min_d) * 64'(min_d);
         if (r2 < fl) r2 = fl;
         // coincident points with no clamp
         if (r2 == 0) return o;
         r   = root(r2);
         gn  = r < cutoff;
         d   = gn ? cutoff - r : r - cutoff;
         g   = 64'(d) * 64'(inv_m);
         den = 96'(r) * 96'(r2);
         o.accel_x = axis(xm, xn, g, gn, den);
         o.accel_y = axis(ym, yn, g, gn, den);
         return o;
      endfunction

      function void note(prf_pkg::req_type q);
         pending = {pending, predict(q)};
      endfunction

      function void check(prf_pkg::rsp_type got);
         prf_pkg::rsp_type want;
         if (pending.size() == 0) begin
            $error("unexpected item: accel_x %h accel_y %h", got.accel_x, got.accel_y);
            fails++;
            return;
         end
         want = pending.pop_front();
         if (got.accel_x !== want.accel_x) begin
            $error("accel_x: expected %h, got %h", want.accel_x, got.accel_x);
            fails++;
         end
         if (got.accel_y !== want.accel_y) begin
            $error("accel_y: expected %h, got %h", want.accel_y, got.accel_y);
            fails++;
         end
         if (got.interacts !== want.interacts) begin
            $error("interacts: expected %b, got %b", want.interacts, got.interacts);
            fails++;
         end
      endfunction
   endclass

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   prf_pkg::req_type              req_item = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b1;
   prf_pkg::rsp_type              rsp_item;
   logic                          csr_valid = 1'b0;
   logic                          csr_ready;
   logic [prf_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [31:0]                   csr_wdata = '0;

   force_scoreboard sb = new();
   bit no_idle   = 1'b0;
   bit hold_req  = 1'b0;
   int idle_cnt  = 0;

   pairwise_repulsive_force uut (
      .clock, .reset, .req_valid, .req_stall, .req_item,
      .rsp_valid, .rsp_stall, .rsp_item,
      .csr_valid, .csr_ready, .csr_index, .csr_wdata
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Check every accepted result
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check(rsp_item);
   end

   // Receiver: random stall per item, plus one long hold on request
   initial begin
      int gap;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_req) begin
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
            hold_req = 1'b0;
         end
         gap = no_idle ? 0 : $urandom_range(0, 6);
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // Watchdog: count cycles with no handshake on any channel
   initial begin
      while (idle_cnt < IDLE_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready))
            idle_cnt = 0;
         else
            idle_cnt++;
      end
      $display("Regression FAIL");
      $finish;
   end

   // Offer one pair and hold it until taken
   task automatic send_pair(prf_pkg::req_type q);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= q;
      do @(posedge clock); while (req_stall);
      sb.note(q);
   endtask

   // Write one register, then leave the channel idle
   task automatic write_reg(logic [prf_pkg::CSR_IDX_W-1:0] idx, logic [31:0] v);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      sb.set_reg(idx, v);
      @(posedge clock);
   endtask

   // Hold off until every expected item is back and the pipeline is empty
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic prf_pkg::req_type pair_of(logic [31:0] ax, logic [31:0] ay,
                                                logic [31:0] bx, logic [31:0] by);
      prf_pkg::req_type q;
      q.own_x = ax; q.own_y = ay; q.other_x = bx; q.other_y = by;
      return q;
   endfunction

   // Mostly neighbors near the cutoff, some fully random pairs
   function automatic prf_pkg::req_type random_pair();
      prf_pkg::req_type q;
      longint           span, offx, offy;
      q.own_x = $urandom;
      q.own_y = $urandom;
      if ($urandom_range(0, 9) < 2) begin
         q.other_x = $urandom;
         q.other_y = $urandom;
      end else begin
         span = 2 * longint'(sb.cutoff) + 2;
         if (span > 64'h1_0000_0000) span = 64'h1_0000_0000;
         offx = longint'({32'd0, $urandom} % span) - span / 2;
         offy = longint'({32'd0, $urandom} % span) - span / 2;
         if ($urandom_range(0, 3) == 0) offy = offy / 64;
         q.other_x = q.own_x + offx[31:0];
         q.other_y = q.own_y + offy[31:0];
      end
      return q;
   endfunction

   task automatic random_phase(int count);
      for (int i = 0; i < count; i++) send_pair(random_pair());
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed pairs at reset settings
      send_pair(pair_of(32'd0, 32'd0, 32'd0, 32'd0));
      send_pair(pair_of(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
      send_pair(pair_of(32'd0, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
      send_pair(pair_of(32'hFFFF_FFFF, 32'd5, 32'd0, 32'd5));
      send_pair(pair_of(32'd1000, 32'd1000, 32'd1000 + 32'd167772, 32'd1000));
      send_pair(pair_of(32'd1000, 32'd1000, 32'd1000 + 32'd167773, 32'd1000));
      send_pair(pair_of(32'd5000, 32'd5000, 32'd5100, 32'd4900));
      send_pair(pair_of(32'd5000, 32'd5000, 32'd5001, 32'd5000));
      send_pair(pair_of(32'h8000_0000, 32'h8000_0000, 32'h7FFF_0000, 32'h8001_0000));
      random_phase(350);
      drain();

      // Widest cutoff, no clamp, heaviest scale: saturation and coincidence
      write_reg(prf_pkg::CSR_CUTOFF_LEN, 32'hFFFF_FFFF);
      write_reg(prf_pkg::CSR_MIN_DIST, 32'd0);
      write_reg(prf_pkg::CSR_INV_MASS, 32'hFFFF_FFFF);
      write_reg(CSR_SPARE, 32'h1234_5678);
      send_pair(pair_of(32'd7, 32'd9, 32'd7, 32'd9));
      send_pair(pair_of(32'd7, 32'd9, 32'd8, 32'd9));
      send_pair(pair_of(32'd0, 32'd0, 32'hFFFF_FFFF, 32'd0));
      send_pair(pair_of(32'hFFFF_FFFF, 32'd0, 32'd0, 32'd1));
      send_pair(pair_of(32'd0, 32'd0, 32'hB504_F333, 32'hB504_F333));
      send_pair(pair_of(32'd0, 32'd0, 32'hB504_F334, 32'hB504_F334));
      random_phase(350);
      drain();

      // Smallest nonzero settings, no idling, with one long receiver hold
      write_reg(prf_pkg::CSR_CUTOFF_LEN, 32'd1);
      write_reg(prf_pkg::CSR_MIN_DIST, 32'd1);
      write_reg(prf_pkg::CSR_INV_MASS, 32'd1);
      no_idle  = 1'b1;
      hold_req = 1'b1;
      random_phase(400);
      no_idle = 1'b0;
      drain();

      // Unit cutoff with a clamp above the cutoff
      write_reg(prf_pkg::CSR_CUTOFF_LEN, 32'h0100_0000);
      write_reg(prf_pkg::CSR_MIN_DIST, 32'h0200_0000);
      write_reg(prf_pkg::CSR_INV_MASS, 32'h0001_0000);
      random_phase(400);
      drain();

      // Random settings
      write_reg(prf_pkg::CSR_CUTOFF_LEN, $urandom);
      write_reg(prf_pkg::CSR_MIN_DIST, $urandom_range(0, 32'h00FF_FFFF));
      write_reg(prf_pkg::CSR_INV_MASS, $urandom);
      random_phase(400);
      drain();

      if (sb.fails == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
